[src/remote_command_byte_decoder_top_macros.svh]
// Assertion macros used by the port checker file.
`ifndef REMOTE_COMMAND_BYTE_DECODER_TOP_MACROS_SVH
`define REMOTE_COMMAND_BYTE_DECODER_TOP_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset
`define RCBD_ASSERT_NOW(label, cond, conseq, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (conseq)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset
`define RCBD_ASSERT_NEXT(label, cond, conseq, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (conseq)) \
      else $error(msg);

`endif

[src/rcbd_pkg.sv]
package rcbd_pkg;

   // Byte codes on the remote link
   localparam logic [7:0] KEY_TURN_ON    = 8'h4B;
   localparam logic [7:0] KEY_TURN_OFF_A = 8'h49;
   localparam logic [7:0] KEY_TURN_OFF_B = 8'h4A;
   localparam logic [7:0] KEY_DIR_FIRST  = 8'h41;
   localparam logic [7:0] KEY_DIR_LAST   = 8'h48;
   localparam logic [7:0] KEY_DIR_BASE   = 8'h40;
   localparam logic [7:0] KEY_FWD        = 8'h41;
   localparam logic [7:0] KEY_BACK       = 8'h45;
   localparam logic [7:0] KEY_RIGHT      = 8'h43;
   localparam logic [7:0] KEY_LEFT       = 8'h47;
   localparam logic [7:0] RAW_DIR_LAST   = 8'h08;
   localparam logic [7:0] FRAME_OPEN     = 8'h7B;
   localparam logic [7:0] FRAME_CLOSE    = 8'h7D;
   localparam logic [7:0] MARK_REPORT    = 8'h50;
   localparam logic [7:0] MARK_SAVE      = 8'h57;
   localparam logic [7:0] SEL_HASH       = 8'h23;
   localparam logic [7:0] SEL_FIRST      = 8'h30;
   localparam logic [7:0] SEL_LAST       = 8'h36;
   localparam logic [7:0] ASCII_ZERO     = 8'h30;

   // Frame positions of interest
   localparam int         POS_WIDTH      = 6;
   localparam logic [5:0] POS_SELECTOR   = 6'd1;
   localparam logic [5:0] POS_MARKER     = 6'd3;

   // Motion state after one byte
   typedef struct packed {
      logic [3:0] direction;
      logic       turn_left;
      logic       turn_right;
      logic       turn_mode;
   } motion_status_type;

   // Frame events raised by one byte
   typedef struct packed {
      logic        param_write;
      logic [2:0]  param_index;
      logic [31:0] param_value;
      logic        report_request;
      logic        save_request;
   } frame_event_type;

endpackage

[src/rcbd_motion.sv]
module rcbd_motion
   import rcbd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic [7:0]        rx_byte,
   input  logic              run_mode,
   output motion_status_type status
);

   logic       turn_ff,  turn_in;
   logic [3:0] dir_ff,   dir_in;
   logic       left_ff,  left_in;
   logic       right_ff, right_in;

   // Turn mode set and clear, then direction and turn flag decode when not in run mode
   always_comb begin
      turn_in  = turn_ff;
      dir_in   = dir_ff;
      left_in  = left_ff;
      right_in = right_ff;

      if (rx_byte == KEY_TURN_ON) begin
         turn_in = 1'b1;
      end else if (rx_byte == KEY_TURN_OFF_A || rx_byte == KEY_TURN_OFF_B) begin
         turn_in = 1'b0;
      end

      if (!run_mode) begin
         if (!turn_in) begin
            if (rx_byte inside {[KEY_DIR_FIRST:KEY_DIR_LAST]}) begin
               dir_in = 4'(rx_byte - KEY_DIR_BASE);
            end else if (rx_byte <= RAW_DIR_LAST) begin
               dir_in = rx_byte[3:0];
            end else begin
               dir_in = 4'd0;
            end
         end else begin
            left_in  = (rx_byte == KEY_LEFT);
            right_in = (rx_byte == KEY_RIGHT);
            if (rx_byte == KEY_FWD || rx_byte == KEY_BACK) begin
               dir_in = 4'(rx_byte - KEY_DIR_BASE);
            end else begin
               dir_in = 4'd0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         turn_ff  <= 1'b0;
         dir_ff   <= 4'd0;
         left_ff  <= 1'b0;
         right_ff <= 1'b0;
      end else if (advance) begin
         turn_ff  <= turn_in;
         dir_ff   <= dir_in;
         left_ff  <= left_in;
         right_ff <= right_in;
      end
   end

   assign status.direction  = dir_in;
   assign status.turn_left  = left_in;
   assign status.turn_right = right_in;
   assign status.turn_mode  = turn_in;

endmodule

[src/rcbd_frame.sv]
module rcbd_frame
   import rcbd_pkg::*;
#(
   parameter int MAX_FRAME   = 50,
   parameter int VALUE_WIDTH = 32
)
(
   input  logic            clock,
   input  logic            reset,
   input  logic            advance,
   input  logic [7:0]      rx_byte,
   output frame_event_type events
);

   localparam logic [POS_WIDTH-1:0] POS_LIMIT = POS_WIDTH'(MAX_FRAME);

   logic                   capturing_ff, capturing_in;
   logic [POS_WIDTH-1:0]   pos_ff,       pos_in;
   logic [7:0]             selector_ff,  selector_in;
   logic [7:0]             marker_ff,    marker_in;
   logic [VALUE_WIDTH-1:0] acc_ff,       acc_in;

   logic [VALUE_WIDTH-1:0] acc_x10;
   logic [VALUE_WIDTH-1:0] acc_step;
   logic [63:0]            acc_wide;
   logic                   is_close;
   logic                   open_now;

   // Horner step: acc*10 + byte - '0', wrapping at the accumulator width
   assign acc_x10  = (acc_ff << 3) + (acc_ff << 1);
   assign acc_step = acc_x10 + VALUE_WIDTH'(rx_byte) - VALUE_WIDTH'(ASCII_ZERO);
   assign acc_wide = 64'(acc_ff);

   assign is_close = (rx_byte == FRAME_CLOSE);
   assign open_now = capturing_ff || (rx_byte == FRAME_OPEN);

   // Capture and close handling
   always_comb begin
      capturing_in = capturing_ff;
      pos_in       = pos_ff;
      selector_in  = selector_ff;
      marker_in    = marker_ff;
      acc_in       = acc_ff;
      events       = '0;

      if (is_close) begin
         if (marker_ff == MARK_REPORT) begin
            events.report_request = 1'b1;
         end else if (marker_ff == MARK_SAVE) begin
            events.save_request = 1'b1;
         end else if (selector_ff != SEL_HASH && selector_ff inside {[SEL_FIRST:SEL_LAST]}) begin
            events.param_write = 1'b1;
            events.param_index = 3'(selector_ff - SEL_FIRST);
            events.param_value = acc_wide[31:0];
         end
         capturing_in = 1'b0;
         pos_in       = '0;
         selector_in  = '0;
         marker_in    = '0;
         acc_in       = '0;
      end else begin
         capturing_in = open_now;
         // bytes past the frame limit are dropped
         if (open_now && pos_ff < POS_LIMIT) begin
            if (pos_ff == POS_SELECTOR) begin
               selector_in = rx_byte;
            end
            if (pos_ff == POS_MARKER) begin
               marker_in = rx_byte;
            end
            if (pos_ff >= POS_MARKER) begin
               acc_in = acc_step;
            end
            pos_in = pos_ff + POS_WIDTH'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capturing_ff <= 1'b0;
         pos_ff       <= '0;
         selector_ff  <= '0;
         marker_ff    <= '0;
         acc_ff       <= '0;
      end else if (advance) begin
         capturing_ff <= capturing_in;
         pos_ff       <= pos_in;
         selector_ff  <= selector_in;
         marker_ff    <= marker_in;
         acc_ff       <= acc_in;
      end
   end

endmodule

[src/remote_command_byte_decoder_top.sv]
// Channel | Direction | Ports                     | Item
// req     | in        | req_valid/req_ready       | rx_byte
// rsp     | out       | rsp_valid/rsp_ready       | direction, turn flags, frame events
// csr     | in        | csr_valid/csr_ready       | run_mode (always ready)
//
// One item per cycle while req_ready is high; each result appears in the cycle
// after its byte is taken. The decode and the Horner step sit between the state
// registers and the result register; that single register stage sets throughput.
// Synchronous active-high reset clears all but the result data; run_mode resets to 0.
// A stalled result holds in the result register while req_ready stays high
// only if the result is being taken in the same cycle.
module remote_command_byte_decoder_top
   import rcbd_pkg::*;
#(
   parameter int MAX_FRAME   = 50,
   parameter int VALUE_WIDTH = 32
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_rx_byte,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [3:0]         rsp_direction,
   output logic               rsp_turn_left,
   output logic               rsp_turn_right,
   output logic               rsp_turn_mode,
   output logic               rsp_param_write,
   output logic [2:0]         rsp_param_index,
   output logic signed [31:0] rsp_param_value,
   output logic               rsp_report_request,
   output logic               rsp_save_request,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_run_mode
);

   logic              run_mode_ff;
   logic              accept;
   logic              rsp_valid_ff, rsp_valid_in;
   motion_status_type motion_now;
   frame_event_type   frame_now;
   motion_status_type motion_ff;
   frame_event_type   frame_ff;

   // Configuration register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_mode_ff <= 1'b0;
      end else if (csr_valid) begin
         run_mode_ff <= csr_run_mode;
      end
   end

   // Take a new item whenever the result register is free or draining
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   rcbd_motion u_motion (
      .clock    (clock),
      .reset    (reset),
      .advance  (accept),
      .rx_byte  (req_rx_byte),
      .run_mode (run_mode_ff),
      .status   (motion_now)
   );

   rcbd_frame #(
      .MAX_FRAME   (MAX_FRAME),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_frame (
      .clock   (clock),
      .reset   (reset),
      .advance (accept),
      .rx_byte (req_rx_byte),
      .events  (frame_now)
   );

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         motion_ff <= motion_now;
         frame_ff  <= frame_now;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_direction      = motion_ff.direction;
   assign rsp_turn_left      = motion_ff.turn_left;
   assign rsp_turn_right     = motion_ff.turn_right;
   assign rsp_turn_mode      = motion_ff.turn_mode;
   assign rsp_param_write    = frame_ff.param_write;
   assign rsp_param_index    = frame_ff.param_index;
   assign rsp_param_value    = frame_ff.param_value;
   assign rsp_report_request = frame_ff.report_request;
   assign rsp_save_request   = frame_ff.save_request;

endmodule

[src/rcbd_checker.sv]
`include "remote_command_byte_decoder_top_macros.svh"

module rcbd_port_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [3:0]         rsp_direction,
   input logic               rsp_turn_left,
   input logic               rsp_turn_right,
   input logic               rsp_param_write,
   input logic [2:0]         rsp_param_index,
   input logic signed [31:0] rsp_param_value,
   input logic               rsp_report_request,
   input logic               rsp_save_request
);

   // At most one frame event per item
   `RCBD_ASSERT_NOW(a_one_event, rsp_valid, $onehot0({rsp_param_write, rsp_report_request, rsp_save_request}), "more than one frame event in one item")

   // Index and value read zero unless a parameter is written
   `RCBD_ASSERT_NOW(a_param_quiet, rsp_valid && !rsp_param_write, rsp_param_index == 3'd0 && rsp_param_value == 32'sd0, "parameter fields set without a write")

   // Direction codes stay within stop and the eight moves
   `RCBD_ASSERT_NOW(a_dir_range, rsp_valid, rsp_direction <= 4'd8, "direction code out of range")

   // Both turn flags never at once
   `RCBD_ASSERT_NOW(a_turn_flags, rsp_valid, !(rsp_turn_left && rsp_turn_right), "left and right turn together")

   // A stalled result holds
   `RCBD_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_direction) && $stable(rsp_param_value), "stalled result changed")

endmodule

bind remote_command_byte_decoder_top rcbd_port_checker u_rcbd_checker (.*);

[dv/rcbd_checker.sv]
`timescale 1ns / 1ps

// Watches the three channels, keeps its own copy of the decoder state and
// compares every result item with the oldest prediction still waiting.
module rcbd_checker
   import rcbd_pkg::*;
#(
   parameter int MAX_FRAME = 50
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [7:0]         req_rx_byte,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [3:0]         rsp_direction,
   input  logic               rsp_turn_left,
   input  logic               rsp_turn_right,
   input  logic               rsp_turn_mode,
   input  logic               rsp_param_write,
   input  logic [2:0]         rsp_param_index,
   input  logic signed [31:0] rsp_param_value,
   input  logic               rsp_report_request,
   input  logic               rsp_save_request,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic               csr_run_mode,
   output int                 fail_count,
   output int                 pending
);

   typedef struct packed {
      motion_status_type motion;
      frame_event_type   frame;
   } decoder_result_type;

   // Shadow of the decoder state
   logic                 run_mode_q;
   logic                 turn_q;
   logic [3:0]           dir_q;
   logic                 left_q;
   logic                 right_q;
   logic                 capturing_q;
   logic [POS_WIDTH-1:0] pos_q;
   logic [7:0]           sel_q;
   logic [7:0]           mark_q;
   logic [31:0]          acc_q;

   decoder_result_type expected_results [$];
   decoder_result_type oldest;
   decoder_result_type predicted;

   task automatic clear_frame_state();
      capturing_q = 1'b0;
      pos_q       = '0;
      sel_q       = '0;
      mark_q      = '0;
      acc_q       = '0;
   endtask

   // Advances the shadow state by one byte and returns the result it causes
   task automatic decode_byte(input logic [7:0] b, output decoder_result_type r);
      logic [7:0] diff;
      diff = b - KEY_DIR_BASE;
      r    = '0;

      // turn mode is tracked whatever the run mode
      if (b == KEY_TURN_ON)
         turn_q = 1'b1;
      else if (b == KEY_TURN_OFF_A || b == KEY_TURN_OFF_B)
         turn_q = 1'b0;

      if (!run_mode_q) begin
         if (!turn_q) begin
            if (b >= KEY_DIR_FIRST && b <= KEY_DIR_LAST)
               dir_q = diff[3:0];
            else if (b <= RAW_DIR_LAST)
               dir_q = b[3:0];
            else
               dir_q = 4'd0;
         end else begin
            left_q  = (b == KEY_LEFT);
            right_q = (b == KEY_RIGHT);
            if (b == KEY_FWD || b == KEY_BACK)
               dir_q = diff[3:0];
            else
               dir_q = 4'd0;
         end
      end

      // frame capture and close
      if (b == FRAME_CLOSE) begin
         if (mark_q == MARK_REPORT) begin
            r.frame.report_request = 1'b1;
         end else if (mark_q == MARK_SAVE) begin
            r.frame.save_request = 1'b1;
         end else if (sel_q != SEL_HASH && sel_q >= SEL_FIRST && sel_q <= SEL_LAST) begin
            diff                = sel_q - SEL_FIRST;
            r.frame.param_write = 1'b1;
            r.frame.param_index = diff[2:0];
            r.frame.param_value = acc_q;
         end
         clear_frame_state();
      end else begin
         if (b == FRAME_OPEN)
            capturing_q = 1'b1;
         // bytes past the frame limit are dropped
         if (capturing_q && pos_q < MAX_FRAME) begin
            if (pos_q == POS_SELECTOR)
               sel_q = b;
            if (pos_q == POS_MARKER)
               mark_q = b;
            if (pos_q >= POS_MARKER)
               acc_q = acc_q * 32'd10 + {24'd0, b} - {24'd0, ASCII_ZERO};
            pos_q = pos_q + 1'b1;
         end
      end

      r.motion.direction  = dir_q;
      r.motion.turn_left  = left_q;
      r.motion.turn_right = right_q;
      r.motion.turn_mode  = turn_q;
   endtask

   task automatic check_field(input string name, input logic [31:0] exp_v,
                              input logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected 0x%08h, got 0x%08h", name, exp_v, act_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         run_mode_q = 1'b0;
         turn_q     = 1'b0;
         dir_q      = 4'd0;
         left_q     = 1'b0;
         right_q    = 1'b0;
         clear_frame_state();
         expected_results.delete();
         fail_count = 0;
      end else begin
         if (csr_valid && csr_ready)
            run_mode_q = csr_run_mode;

         // result items belong to earlier bytes, so compare before pushing
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $error("result item arrived with no prediction waiting");
               fail_count++;
            end else begin
               oldest = expected_results.pop_front();
               check_field("direction", 32'(oldest.motion.direction), 32'(rsp_direction));
               check_field("turn_left", 32'(oldest.motion.turn_left), 32'(rsp_turn_left));
               check_field("turn_right", 32'(oldest.motion.turn_right),
                           32'(rsp_turn_right));
               check_field("turn_mode", 32'(oldest.motion.turn_mode), 32'(rsp_turn_mode));
               check_field("param_write", 32'(oldest.frame.param_write),
                           32'(rsp_param_write));
               check_field("param_index", 32'(oldest.frame.param_index),
                           32'(rsp_param_index));
               check_field("param_value", oldest.frame.param_value, rsp_param_value);
               check_field("report_request", 32'(oldest.frame.report_request),
                           32'(rsp_report_request));
               check_field("save_request", 32'(oldest.frame.save_request),
                           32'(rsp_save_request));
            end
         end

         if (req_valid && req_ready) begin
            decode_byte(req_rx_byte, predicted);
            expected_results.push_back(predicted);
         end
      end
      pending = expected_results.size();
   end

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
   import rcbd_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_ITEMS    = 95;

   logic               clock;
   logic               reset        = 1'b1;
   logic               req_valid    = 1'b0;
   logic               req_ready;
   logic [7:0]         req_rx_byte  = 8'd0;
   logic               rsp_valid;
   logic               rsp_ready    = 1'b0;
   logic [3:0]         rsp_direction;
   logic               rsp_turn_left;
   logic               rsp_turn_right;
   logic               rsp_turn_mode;
   logic               rsp_param_write;
   logic [2:0]         rsp_param_index;
   logic signed [31:0] rsp_param_value;
   logic               rsp_report_request;
   logic               rsp_save_request;
   logic               csr_valid    = 1'b0;
   logic               csr_ready;
   logic               csr_run_mode = 1'b0;

   int fail_count;
   int pending;
   int sent_count    = 0;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int idle_cycles   = 0;

   logic [7:0] directed_bytes [$] = '{
      8'h00, RAW_DIR_LAST, 8'h09, KEY_DIR_FIRST, KEY_DIR_LAST, 8'hFF,
      KEY_TURN_ON, KEY_RIGHT, KEY_LEFT, KEY_BACK, 8'h42, KEY_TURN_OFF_A,
      KEY_TURN_ON, KEY_TURN_OFF_B,
      FRAME_OPEN, SEL_LAST, SEL_HASH, 8'h39, 8'h39, FRAME_CLOSE,
      FRAME_OPEN, SEL_FIRST, 8'h2C, MARK_REPORT, FRAME_CLOSE,
      FRAME_CLOSE
   };

   remote_command_byte_decoder_top u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_direction      (rsp_direction),
      .rsp_turn_left      (rsp_turn_left),
      .rsp_turn_right     (rsp_turn_right),
      .rsp_turn_mode      (rsp_turn_mode),
      .rsp_param_write    (rsp_param_write),
      .rsp_param_index    (rsp_param_index),
      .rsp_param_value    (rsp_param_value),
      .rsp_report_request (rsp_report_request),
      .rsp_save_request   (rsp_save_request),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_run_mode       (csr_run_mode)
   );

   rcbd_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_direction      (rsp_direction),
      .rsp_turn_left      (rsp_turn_left),
      .rsp_turn_right     (rsp_turn_right),
      .rsp_turn_mode      (rsp_turn_mode),
      .rsp_param_write    (rsp_param_write),
      .rsp_param_index    (rsp_param_index),
      .rsp_param_value    (rsp_param_value),
      .rsp_report_request (rsp_report_request),
      .rsp_save_request   (rsp_save_request),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_run_mode       (csr_run_mode),
      .fail_count         (fail_count),
      .pending            (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Result side back-pressure
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   // Watchdog: ends the run once nothing has moved for too long
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
                   (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Offers one byte, with random gaps first; called and left at a falling edge
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!req_ready);
      sent_count++;
      @(negedge clock);
   endtask

   // Stops the sender until every predicted item has come back
   task automatic settle_block();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   task automatic write_run_mode(input logic mode);
      csr_valid    <= 1'b1;
      csr_run_mode <= mode;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [7:0] random_digit();
      logic [7:0] d;
      d = 8'($urandom_range(0, 9));
      return d + ASCII_ZERO;
   endfunction

   function automatic logic [7:0] random_motion_byte();
      logic [7:0] b;
      case ($urandom_range(0, 5))
         0: b = KEY_TURN_ON;
         1: b = KEY_TURN_OFF_A;
         2: b = KEY_TURN_OFF_B;
         3: b = 8'($urandom_range(0, 8));
         4: begin
            b = 8'($urandom_range(0, 7));
            b = b + KEY_DIR_FIRST;
         end
         default: begin
            case ($urandom_range(0, 3))
               0:       b = KEY_LEFT;
               1:       b = KEY_RIGHT;
               2:       b = KEY_FWD;
               default: b = KEY_BACK;
            endcase
         end
      endcase
      return b;
   endfunction

   // One brace frame with random content; long ones run past the frame limit
   task automatic send_frame(input bit long_frame);
      logic [7:0] b;
      int         kind;
      int         body_len;
      send_byte(FRAME_OPEN);

      // selector
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
         b = 8'($urandom_range(0, 6));
         b = b + SEL_FIRST;
      end else if (kind == 7) begin
         b = SEL_HASH;
      end else begin
         b = 8'($urandom_range(0, 255));
      end
      send_byte(b);

      // filler at position 2
      send_byte(($urandom_range(0, 1) == 0) ? 8'h2C : 8'($urandom_range(0, 255)));

      // marker, also the first digit
      kind = $urandom_range(0, 9);
      if (kind == 0)
         b = MARK_REPORT;
      else if (kind == 1)
         b = MARK_SAVE;
      else if (kind == 2)
         b = 8'($urandom_range(0, 255));
      else
         b = random_digit();
      send_byte(b);

      body_len = long_frame ? $urandom_range(50, 60) : $urandom_range(0, 11);
      for (int i = 0; i < body_len; i++) begin
         if ($urandom_range(0, 9) == 0)
            b = 8'($urandom_range(0, 255));
         else
            b = random_digit();
         send_byte(b);
      end

      // now and then the frame is left open
      if ($urandom_range(0, 11) != 0)
         send_byte(FRAME_CLOSE);
   endtask

   task automatic send_random_item();
      int k;
      k = $urandom_range(0, 99);
      if (k < 55) begin
         send_frame(k < 3);
      end else if (k < 75) begin
         send_byte(random_motion_byte());
      end else if (k < 85) begin
         if ($urandom_range(0, 1) == 0) begin
            send_byte(FRAME_CLOSE);
         end else begin
            send_byte(FRAME_OPEN);
            send_byte(8'($urandom_range(0, 255)));
            send_byte(FRAME_CLOSE);
         end
      end else begin
         send_byte(8'($urandom_range(0, 255)));
      end
   endtask

   task automatic run_phase(input int items);
      int target;
      target = sent_count + items;
      while (sent_count < target) send_random_item();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      write_run_mode(1'b0);

      // directed bytes: direction extremes, turn keys, a parameter write frame, a report frame and a stray close
      foreach (directed_bytes[i]) send_byte(directed_bytes[i]);

      // no idling
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      run_phase(PHASE_ITEMS);
      settle_block();

      // sender mostly idle, motion decoding suspended
      write_run_mode(1'b1);
      send_idle_pct = 81;
      rsp_stall_pct = 0;
      run_phase(PHASE_ITEMS);
      settle_block();

      // receiver mostly stalling
      write_run_mode(1'b0);
      send_idle_pct = 0;
      rsp_stall_pct = 81;
      run_phase(PHASE_ITEMS);
      settle_block();

      // both sides idling now and then
      write_run_mode(1'b1);
      send_idle_pct = 23;
      rsp_stall_pct = 23;
      run_phase(PHASE_ITEMS);
      settle_block();

      repeat (4) @(negedge clock);
      if (fail_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
